/* rtl/core/aavr_pkg.sv */
// Package: shared constants and CORDIC arctangent table for the axis-angle rotator.
`timescale 1ns / 1ps
package aavr_pkg;

  localparam int VEC_BITS_DEF   = 16;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int AXIS_BITS      = 16;
  localparam int CORDIC_STEPS   = 16;
  localparam int TURN_BITS      = 32;
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [15:0] ONE_Q14     = 16'sd16384;

  // arctangent of 2^-i in units of a 2^32 full turn
  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

endpackage

/* rtl/core/aavr_if.sv */
// Interfaces: input and result channels of the axis-angle rotator.
`timescale 1ns / 1ps
interface aavr_in_if #(
  parameter int VecBits   = aavr_pkg::VEC_BITS_DEF,
  parameter int AngleBits = aavr_pkg::ANGLE_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [15:0]          axis_x;
  logic signed [15:0]          axis_y;
  logic signed [15:0]          axis_z;
  logic signed [VecBits-1:0]   vec_x;
  logic signed [VecBits-1:0]   vec_y;
  logic signed [VecBits-1:0]   vec_z;
  logic        [AngleBits-1:0] angle;

  modport source (output valid, axis_x, axis_y, axis_z, vec_x, vec_y, vec_z, angle,
                  input ready);
  modport sink   (input valid, axis_x, axis_y, axis_z, vec_x, vec_y, vec_z, angle,
                  output ready);
endinterface

interface aavr_out_if #(
  parameter int VecBits = aavr_pkg::VEC_BITS_DEF
);
  logic                      valid;
  logic                      ready;
  logic signed [VecBits-1:0] out_x;
  logic signed [VecBits-1:0] out_y;
  logic signed [VecBits-1:0] out_z;
  logic                      saturated;

  modport source (output valid, out_x, out_y, out_z, saturated, input ready);
  modport sink   (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

/* rtl/core/axis_angle_vector_rotation_top.sv */
// Top level: pipelined Rodrigues axis-angle rotation of a 3D vector.
`timescale 1ns / 1ps
// Rotates vector v about unit axis k (Q1.14) by a binary angle, giving
// v*cos + (k x v)*sin + k*(k.v)*(1-cos), each component saturated to VEC_BITS.
// The axis is used as given and is not normalized. A fully pipelined datapath
// of 14 register stages takes one transaction per cycle while the output is
// not stalled; sine and cosine come from a 16-step CORDIC unrolled two steps
// per stage over 8 stages. Every stage holds its item under backpressure, so
// a stalled output fills the pipeline first.
module axis_angle_vector_rotation_top #(
  parameter int VEC_BITS   = aavr_pkg::VEC_BITS_DEF,
  parameter int ANGLE_BITS = aavr_pkg::ANGLE_BITS_DEF
) (
  input logic   clk_i,
  input logic   rst_ni,
  aavr_in_if.sink    in_i,
  aavr_out_if.source out_o
);
  import aavr_pkg::*;

  localparam int V    = VEC_BITS;
  localparam int PW   = V + 18;  // k.v
  localparam int DW   = V + 11;  // d
  localparam int DTW  = DW + 17; // d*t
  localparam int EW   = V + 14;  // e
  localparam int CW   = V + 17;  // cross product
  localparam int CSPW = CW + 16; // cross*s
  localparam int CSW  = V + 19;  // rounded cross*s
  localparam int VCW  = V + 16;  // v*c
  localparam int KPW  = EW + 16; // k*e
  localparam int KEW  = V + 23;  // rounded k*e
  localparam int SW   = V + 25;  // sum
  localparam int RW   = V + 11;  // rounded sum

  localparam int S_IN    = 0;
  localparam int S_CORD0 = 1;
  localparam int N_CORD  = CORDIC_STEPS / 2;
  localparam int S_SC    = S_CORD0 + N_CORD;
  localparam int S_D     = S_SC + 1;
  localparam int S_E     = S_D + 1;
  localparam int S_KE    = S_E + 1;
  localparam int S_OUT   = S_KE + 1;
  localparam int NST     = S_OUT + 1;

  typedef struct packed {
    logic [2:0][15:0]     k;
    logic [2:0][V-1:0]    v;
    logic [1:0]           quad;
    logic signed [32:0]   x;
    logic signed [32:0]   y;
    logic signed [31:0]   z;
    logic signed [PW-1:0] p;
    logic [2:0][CW-1:0]   cr;
    logic signed [15:0]   c;
    logic signed [15:0]   s;
    logic signed [DW-1:0] d;
    logic signed [16:0]   t;
    logic signed [EW-1:0] e;
    logic [2:0][CSW-1:0]  crs;
    logic [2:0][VCW-1:0]  vc;
    logic [2:0][KEW-1:0]  ke;
    logic [2:0][V-1:0]    o;
    logic                 sat;
  } stage_t;

  stage_t stg_q [NST];
  stage_t stg_d [NST];
  logic [NST-1:0] vld_q;
  logic [NST-1:0] en;

  // ready chain: a stage loads when empty or when its item moves on
  always_comb begin
    en[NST-1] = !vld_q[NST-1] || out_o.ready;
    for (int j = NST - 2; j >= 0; j--) begin
      en[j] = !vld_q[j] || en[j+1];
    end
  end

  assign in_i.ready = en[0];

  // per-stage datapath
  always_comb begin
    logic [TURN_BITS-1:0]  turn;
    logic signed [15:0]    ks [3];
    logic signed [V-1:0]   vs [3];
    logic signed [32:0]    cx, cy, xs, ys;
    logic signed [31:0]    cz;
    logic signed [32:0]    rx, ry;
    logic signed [15:0]    c0, s0;
    logic signed [DTW-1:0] dt;
    logic signed [CSPW-1:0] csp;
    logic signed [KPW-1:0] kp;
    logic signed [SW-1:0]  sum;
    logic signed [RW-1:0]  r, hi_c, lo_c;
    int                    st;
    cx   = '0;
    cy   = '0;
    cz   = '0;
    xs   = '0;
    ys   = '0;
    rx   = '0;
    ry   = '0;
    c0   = '0;
    s0   = '0;
    dt   = '0;
    csp  = '0;
    kp   = '0;
    sum  = '0;
    r    = '0;
    st   = 0;
    hi_c = RW'({1'b0, {(V-1){1'b1}}});
    lo_c = -hi_c - RW'(1);
    turn = TURN_BITS'(in_i.angle) << (TURN_BITS - ANGLE_BITS);
    for (int j = 0; j < NST; j++) begin
      if (j == S_IN) begin
        stg_d[j]      = stg_q[j];
        stg_d[j].k    = {in_i.axis_z, in_i.axis_y, in_i.axis_x};
        stg_d[j].v    = {in_i.vec_z, in_i.vec_y, in_i.vec_x};
        stg_d[j].quad = turn[31:30];
        stg_d[j].x    = CORDIC_GAIN;
        stg_d[j].y    = '0;
        stg_d[j].z    = {2'b00, turn[29:0]};
      end else begin
        stg_d[j] = stg_q[j-1];
      end
      for (int i = 0; i < 3; i++) begin
        ks[i] = $signed(stg_d[j].k[i]);
        vs[i] = $signed(stg_d[j].v[i]);
      end

      // CORDIC, two steps per stage; dot and cross products in the first one
      if (j >= S_CORD0 && j < S_SC) begin
        if (j == S_CORD0) begin
          stg_d[j].p = PW'(ks[0]) * PW'(vs[0]) + PW'(ks[1]) * PW'(vs[1])
                     + PW'(ks[2]) * PW'(vs[2]);
          stg_d[j].cr[0] = CW'(CW'(ks[1]) * CW'(vs[2]) - CW'(ks[2]) * CW'(vs[1]));
          stg_d[j].cr[1] = CW'(CW'(ks[2]) * CW'(vs[0]) - CW'(ks[0]) * CW'(vs[2]));
          stg_d[j].cr[2] = CW'(CW'(ks[0]) * CW'(vs[1]) - CW'(ks[1]) * CW'(vs[0]));
        end
        cx = stg_d[j].x;
        cy = stg_d[j].y;
        cz = stg_d[j].z;
        for (int m = 0; m < 2; m++) begin
          st = 2 * (j - S_CORD0) + m;
          xs = cx >>> st;
          ys = cy >>> st;
          if (!cz[31]) begin
            cx = cx - ys;
            cy = cy + xs;
            cz = cz - $signed(ATAN_TURNS[st]);
          end else begin
            cx = cx + ys;
            cy = cy - xs;
            cz = cz + $signed(ATAN_TURNS[st]);
          end
        end
        stg_d[j].x = cx;
        stg_d[j].y = cy;
        stg_d[j].z = cz;
      end

      // round to Q1.14, clamp, quadrant map
      if (j == S_SC) begin
        rx = (stg_d[j].x >>> 16) + $signed({32'd0, stg_d[j].x[15]});
        ry = (stg_d[j].y >>> 16) + $signed({32'd0, stg_d[j].y[15]});
        if (rx > 33'(ONE_Q14)) c0 = ONE_Q14;
        else if (rx < -33'(ONE_Q14)) c0 = -ONE_Q14;
        else c0 = 16'(rx);
        if (ry > 33'(ONE_Q14)) s0 = ONE_Q14;
        else if (ry < -33'(ONE_Q14)) s0 = -ONE_Q14;
        else s0 = 16'(ry);
        case (stg_d[j].quad)
          2'd0:    begin stg_d[j].c = c0;  stg_d[j].s = s0;  end
          2'd1:    begin stg_d[j].c = -s0; stg_d[j].s = c0;  end
          2'd2:    begin stg_d[j].c = -c0; stg_d[j].s = -s0; end
          default: begin stg_d[j].c = s0;  stg_d[j].s = -c0; end
        endcase
      end

      // t = 1 - c, d = k.v in Q7
      if (j == S_D) begin
        stg_d[j].t = 17'(ONE_Q14) - 17'(stg_d[j].c);
        stg_d[j].d = DW'(stg_d[j].p >>> 7) + DW'(stg_d[j].p[6]);
      end

      // e, cross*s, v*c
      if (j == S_E) begin
        dt = DTW'(stg_d[j].d) * DTW'(stg_d[j].t);
        stg_d[j].e = EW'(dt >>> 14) + EW'(dt[13]);
        for (int i = 0; i < 3; i++) begin
          csp = CSPW'($signed(stg_d[j].cr[i])) * CSPW'(stg_d[j].s);
          stg_d[j].crs[i] = CSW'(csp >>> 14) + CSW'(csp[13]);
          stg_d[j].vc[i]  = VCW'(vs[i]) * VCW'(stg_d[j].c);
        end
      end

      // k*e
      if (j == S_KE) begin
        for (int i = 0; i < 3; i++) begin
          kp = KPW'(ks[i]) * KPW'(stg_d[j].e);
          stg_d[j].ke[i] = KEW'(kp >>> 7) + KEW'(kp[6]);
        end
      end

      // final sum, round, saturate
      if (j == S_OUT) begin
        stg_d[j].sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
          sum = SW'($signed(stg_d[j].vc[i])) + SW'($signed(stg_d[j].crs[i]))
              + SW'($signed(stg_d[j].ke[i]));
          r = RW'(sum >>> 14) + RW'(sum[13]);
          if (r > hi_c) begin
            r = hi_c;
            stg_d[j].sat = 1'b1;
          end else if (r < lo_c) begin
            r = lo_c;
            stg_d[j].sat = 1'b1;
          end
          stg_d[j].o[i] = V'(r);
        end
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[S_IN]) begin
        vld_q[S_IN] <= in_i.valid;
      end
      for (int j = 1; j < NST; j++) begin
        if (en[j]) begin
          vld_q[j] <= vld_q[j-1];
        end
      end
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < NST; j++) begin
      if (en[j]) begin
        stg_q[j] <= stg_d[j];
      end
    end
  end

  assign out_o.valid     = vld_q[NST-1];
  assign out_o.out_x     = $signed(stg_q[NST-1].o[0]);
  assign out_o.out_y     = $signed(stg_q[NST-1].o[1]);
  assign out_o.out_z     = $signed(stg_q[NST-1].o[2]);
  assign out_o.saturated = stg_q[NST-1].sat;

endmodule
